FILE: design/ipf_pkg.sv
// Package for the IP address text formatter.
// Holds the character codes, the hex digit table and the structs shared by
// the modules. No dependencies.
`default_nettype none

package ipf_pkg;

  // Address text modes
  typedef enum logic [1:0] {
    MODE_V4      = 2'd0,
    MODE_V6      = 2'd1,
    MODE_V4_PORT = 2'd2,
    MODE_V6_PORT = 2'd3
  } mode_t;

  // Fixed punctuation
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_COLON = 7'h3A;
  localparam logic [6:0] CH_LBRK  = 7'h5B;
  localparam logic [6:0] CH_RBRK  = 7'h5D;

  // Lower-case hex digits; decimal digits are the first ten entries
  localparam logic [6:0] HexChars [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
  };

  // Request to the binary-to-decimal converter
  typedef struct packed {
    logic        start;
    logic        wide;   // 1: 16-bit port, 0: 8-bit octet
    logic [15:0] value;
  } bcd_req_t;

  // Converter response: done pulses once, digits hold until the next start
  typedef struct packed {
    logic        done;
    logic [19:0] digits;
  } bcd_rsp_t;

  // First compressible zero run of an IPv6 address
  typedef struct packed {
    logic       found;
    logic [2:0] first;  // first group of the run
    logic [3:0] stop;   // first nonzero group after the run, 8 if none
  } zrun_t;

  function automatic logic [6:0] hex_char(input logic [3:0] d);
    return HexChars[d];
  endfunction

endpackage

`default_nettype wire

FILE: design/ipf_in_if.sv
// Input channel of the IP address text formatter: one address per transaction.
// Standalone; no package needed.
`default_nettype none

interface ipf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [15:0] port;

  modport source (output valid, output mode, output addr_high, output addr_low,
                  output port, input ready);
  modport sink   (input valid, input mode, input addr_high, input addr_low,
                  input port, output ready);
endinterface

`default_nettype wire

FILE: design/ipf_out_if.sv
// Output channel of the IP address text formatter: one character per transaction.
// Standalone; no package needed.
`default_nettype none

interface ipf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

FILE: design/ip_address_text_formatter.sv
// Top level of the IP address text formatter: character sequencer and output register.
// Depends on ipf_pkg, ipf_in_if, ipf_out_if, ipf_bcd and ipf_zrun.
//
//   channel   role    payload                              transaction
//   req       sink    mode, addr_high, addr_low, port      one address
//   text      source  char_code, last                      one character
//
// One address is in work at a time; req is ready only while the sequencer idles.
// Each hex group is loaded and its digits are emitted with leading zeros dropped; a colon
// separates it from the next group. Each decimal number is started, converted by ipf_bcd
// (a load, then one bit at a time), its digits are loaded, and its three (octet) or five
// (port) digits are emitted with leading zeros dropped.
// Reset is synchronous and empties the output register; a stalled text channel
// holds the sequencer on its next character.
`default_nettype none

module ip_address_text_formatter (
  input wire logic clk,
  input wire logic rst,
  ipf_in_if.sink   req,
  ipf_out_if.source text
);
  import ipf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_OPEN, S_OCT, S_PORT, S_WAIT, S_DIG, S_GRP,
    S_DCOL, S_SKIP, S_DOT, S_COLG, S_COLP, S_CLOSE
  } state_t;

  typedef enum logic [1:0] {PH_OCT, PH_GRP, PH_PORT} phase_t;

  state_t       state;
  phase_t       phase;
  mode_t        mode;
  logic [127:0] addr;
  logic [15:0]  port_val;
  zrun_t        run;
  zrun_t        run_in;
  logic [3:0]   g;
  logic [1:0]   k;
  logic [19:0]  dig;
  logic [2:0]   dcnt;
  logic         dig_last;
  logic         started;
  logic         ov;
  logic [6:0]   oc;
  logic         ol;
  logic         bcd_start;
  logic         bcd_wide;
  logic [15:0]  bcd_value;
  bcd_req_t     bcd_req;
  bcd_rsp_t     bcd_rsp;
  logic         can_emit;
  logic [3:0]   digit;

  ipf_zrun u_zrun (
    .addr ({req.addr_high, req.addr_low}),
    .run  (run_in)
  );

  assign bcd_req.start = bcd_start;
  assign bcd_req.wide  = bcd_wide;
  assign bcd_req.value = bcd_value;

  ipf_bcd u_bcd (
    .clk (clk),
    .rst (rst),
    .req (bcd_req),
    .rsp (bcd_rsp)
  );

  assign can_emit       = !ov || text.ready;
  assign digit          = dig[19:16];
  assign req.ready      = (state == S_IDLE);
  assign text.valid     = ov;
  assign text.char_code = oc;
  assign text.last      = ol;

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ov        <= 1'b0;
      bcd_start <= 1'b0;
    end else begin
      bcd_start <= 1'b0;
      if (text.ready) begin
        ov <= 1'b0;
      end
      case (state)
        // Capture the address and pick the first step
        S_IDLE: begin
          if (req.valid) begin
            mode     <= mode_t'(req.mode);
            port_val <= req.port;
            run      <= run_in;
            g        <= 4'd0;
            k        <= 2'd0;
            if (req.mode[0]) begin
              addr <= {req.addr_high, req.addr_low};
            end else begin
              addr <= {req.addr_low[31:0], 96'h0};
            end
            case (mode_t'(req.mode))
              MODE_V4, MODE_V4_PORT: state <= S_OCT;
              MODE_V6:               state <= S_GRP;
              default:               state <= S_OPEN;
            endcase
          end
        end
        S_OPEN: begin
          if (can_emit) begin
            ov    <= 1'b1;
            oc    <= CH_LBRK;
            ol    <= 1'b0;
            state <= S_GRP;
          end
        end
        // Start decimal conversion of the next octet
        S_OCT: begin
          bcd_start <= 1'b1;
          bcd_wide  <= 1'b0;
          bcd_value <= {8'h00, addr[127:120]};
          addr      <= addr << 8;
          phase     <= PH_OCT;
          dig_last  <= (k == 2'd3) && (mode == MODE_V4);
          state     <= S_WAIT;
        end
        S_PORT: begin
          bcd_start <= 1'b1;
          bcd_wide  <= 1'b1;
          bcd_value <= port_val;
          phase     <= PH_PORT;
          dig_last  <= 1'b1;
          state     <= S_WAIT;
        end
        // Load the finished digits, most significant first
        S_WAIT: begin
          if (bcd_rsp.done) begin
            if (phase == PH_PORT) begin
              dig  <= bcd_rsp.digits;
              dcnt <= 3'd5;
            end else begin
              dig  <= {bcd_rsp.digits[11:0], 8'h00};
              dcnt <= 3'd3;
            end
            started <= 1'b0;
            state   <= S_DIG;
          end
        end
        // Drop leading zeros, emit the rest one digit per cycle while the text channel takes them
        S_DIG: begin
          if (digit == 4'd0 && !started && dcnt != 3'd1) begin
            dig  <= dig << 4;
            dcnt <= dcnt - 3'd1;
          end else if (can_emit) begin
            ov      <= 1'b1;
            oc      <= hex_char(digit);
            ol      <= dig_last && (dcnt == 3'd1);
            started <= 1'b1;
            dig     <= dig << 4;
            dcnt    <= dcnt - 3'd1;
            if (dcnt == 3'd1) begin
              case (phase)
                PH_OCT: begin
                  if (k != 2'd3) begin
                    state <= S_DOT;
                  end else if (mode == MODE_V4_PORT) begin
                    state <= S_COLP;
                  end else begin
                    state <= S_IDLE;
                  end
                end
                PH_GRP: begin
                  state <= (g == 4'd8) ? S_GRP : S_COLG;
                end
                default: state <= S_IDLE;
              endcase
            end
          end
        end
        // Next IPv6 group: finish, compress or load its nibbles
        S_GRP: begin
          if (g == 4'd8) begin
            state <= (mode == MODE_V6_PORT) ? S_CLOSE : S_IDLE;
          end else if (run.found && g[2:0] == run.first) begin
            if (can_emit) begin
              ov    <= 1'b1;
              oc    <= CH_COLON;
              ol    <= (g != 4'd0) && (run.stop == 4'd8) && (mode == MODE_V6);
              state <= (g == 4'd0) ? S_DCOL : S_SKIP;
            end
          end else begin
            dig      <= {addr[127:112], 4'h0};
            dcnt     <= 3'd4;
            started  <= 1'b0;
            phase    <= PH_GRP;
            dig_last <= (g == 4'd7) && (mode == MODE_V6);
            addr     <= addr << 16;
            g        <= g + 4'd1;
            state    <= S_DIG;
          end
        end
        S_DCOL: begin
          if (can_emit) begin
            ov    <= 1'b1;
            oc    <= CH_COLON;
            ol    <= (run.stop == 4'd8) && (mode == MODE_V6);
            state <= S_SKIP;
          end
        end
        // Advance past the compressed zero groups
        S_SKIP: begin
          if (g == run.stop) begin
            state <= S_GRP;
          end else begin
            addr <= addr << 16;
            g    <= g + 4'd1;
          end
        end
        S_DOT: begin
          if (can_emit) begin
            ov    <= 1'b1;
            oc    <= CH_DOT;
            ol    <= 1'b0;
            k     <= k + 2'd1;
            state <= S_OCT;
          end
        end
        S_COLG: begin
          if (can_emit) begin
            ov    <= 1'b1;
            oc    <= CH_COLON;
            ol    <= 1'b0;
            state <= S_GRP;
          end
        end
        S_COLP: begin
          if (can_emit) begin
            ov    <= 1'b1;
            oc    <= CH_COLON;
            ol    <= 1'b0;
            state <= S_PORT;
          end
        end
        S_CLOSE: begin
          if (can_emit) begin
            ov    <= 1'b1;
            oc    <= CH_RBRK;
            ol    <= 1'b0;
            state <= S_COLP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/ipf_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on ipf_pkg for the request and response structs.
`default_nettype none

module ipf_bcd (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ipf_pkg::bcd_req_t req,
  output ipf_pkg::bcd_rsp_t      rsp
);
  import ipf_pkg::*;

  logic [15:0] bin;
  logic [19:0] bcd;
  logic [19:0] adj;
  logic [4:0]  cnt;
  logic        done;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // Load, then shift one binary bit into the digits per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 5'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        bin <= req.wide ? req.value : {req.value[7:0], 8'h00};
        bcd <= 20'h00000;
        cnt <= req.wide ? 5'd16 : 5'd8;
      end else if (cnt != 5'd0) begin
        bcd <= {adj[18:0], bin[15]};
        bin <= {bin[14:0], 1'b0};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.digits = bcd;

endmodule

`default_nettype wire

FILE: design/ipf_zrun.sv
// Finder for the first run of three or more zero groups starting at group 0..5.
// Depends on ipf_pkg for zrun_t.
`default_nettype none

module ipf_zrun (
  input  wire logic [127:0] addr,
  output ipf_pkg::zrun_t    run
);
  import ipf_pkg::*;

  logic [7:0] zero;

  // Flag each all-zero group, group 0 in the top bits
  always_comb begin
    for (int g = 0; g < 8; g++) begin
      zero[g] = (addr[127 - 16*g -: 16] == 16'h0000);
    end
  end

  // Pick the earliest run start, then the first nonzero group past it
  always_comb begin
    run.found = 1'b0;
    run.first = 3'd0;
    run.stop  = 4'd8;
    for (int g = 5; g >= 0; g--) begin
      if (zero[g] && zero[g+1] && zero[g+2]) begin
        run.found = 1'b1;
        run.first = 3'(g);
      end
    end
    for (int g = 7; g >= 0; g--) begin
      if (g >= int'(run.first) + 3 && !zero[g]) begin
        run.stop = 4'(g);
      end
    end
  end

endmodule

`default_nettype wire
